// ----- rtl/core/nssag_pkg.sv -----
// shared types, constants and command codes of the strided slice row address generator
`timescale 1ns / 1ps

package nssag_pkg;

    // rank of the tensor, outer dimensions walked by the sequencer
    localparam int MAX_RANK    = 8;
    localparam int OUTER_DIMS  = MAX_RANK - 1;
    localparam int DIM_W       = (OUTER_DIMS > 1) ? $clog2(OUTER_DIMS) : 1;

    // field widths
    localparam int CMD_W       = 2;
    localparam int IDX_W       = 4;
    localparam int EXT_W       = 16;
    localparam int EB_W        = 4;
    localparam int ROW_W       = 32;
    localparam int PAGE_W      = 32;
    localparam int BYTES_W     = 19;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [BYTES_W-1:0] ROW_BYTES_MAX = '1;

    // item commands
    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STEP    = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_SIZE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_START = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_END   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_STEP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_ELEMS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEM_BYTES = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ROW  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT  = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [IDX_W-1:0] dim_index;
        logic [EXT_W-1:0] dim_size;
        logic [EXT_W-1:0] dim_start;
        logic [EXT_W-1:0] dim_end;
        logic [EXT_W-1:0] dim_step;
    } t_in_item;

    typedef struct packed {
        logic               row_emitted;
        logic [PAGE_W-1:0]  page_index;
        logic [BYTES_W-1:0] row_bytes;
        logic               needs_compaction;
        logic               done_res;
    } t_out_item;

    // requests from the control to the dimension walker
    typedef struct packed {
        logic     start;
        logic     load;
        logic     restart;
        t_in_item item;
    } t_walk_req;

    // walker status back to the control
    typedef struct packed {
        logic              done;
        logic              finished;
        logic [PAGE_W-1:0] page;
    } t_walk_rsp;

endpackage

// ----- rtl/core/nd_strided_slice_row_address_gen_core.sv -----
// top level: handshakes, configuration registers, row counters and result register
// load, restart and unknown items, and steps on a finished walk, give their result
// in the output register after acceptance, once it is free; a step item's result
// waits for the walk on the shared 32x16 multiplier, an accumulate and a size phase
// on each of the seven outer dimensions; the input stalls until the result is registered.
// reset is synchronous and active low: all state but the output data resets at once.
`timescale 1ns / 1ps

module nd_strided_slice_row_address_gen_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  nssag_pkg::t_in_item                i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output nssag_pkg::t_out_item               o_out_item,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [nssag_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [nssag_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import nssag_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_RESP = 2'd2;

    // configuration
    logic [EXT_W-1:0] r_last_size;
    logic [EXT_W-1:0] r_last_start;
    logic [EXT_W-1:0] r_last_end;
    logic [EXT_W-1:0] r_last_step;
    logic [EXT_W-1:0] r_out_elems;
    logic [EB_W-1:0]  r_elem_bytes;
    logic [ROW_W-1:0] r_first_row;
    logic [ROW_W-1:0] r_row_count;

    // walk state
    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [ROW_W-1:0] r_logical_row;
    logic [ROW_W-1:0] r_rows_done;
    logic             r_start_found;
    logic             r_walk_finished;
    logic             r_emit;
    logic             r_out_valid;
    t_out_item        r_out;

    t_walk_req        w_req;
    t_walk_rsp        w_rsp;
    logic             w_accept;
    logic             w_cfg_wr;
    logic             w_done;
    logic             w_out_free;
    logic             w_emit_now;
    logic [EXT_W+EB_W-1:0] w_bytes;
    logic [BYTES_W-1:0]    w_bytes_sat;
    logic             w_compact;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_done      = r_walk_finished || (r_rows_done >= r_row_count);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_emit_now  = r_start_found || (r_logical_row == r_first_row);

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_size  <= EXT_W'(1);
            r_last_start <= '0;
            r_last_end   <= EXT_W'(1);
            r_last_step  <= EXT_W'(1);
            r_out_elems  <= EXT_W'(1);
            r_elem_bytes <= EB_W'(1);
            r_first_row  <= '0;
            r_row_count  <= '0;
        end else if (w_cfg_wr) begin
            unique case (i_cfg_index)
                CFG_LAST_SIZE:  r_last_size  <= i_cfg_data[EXT_W-1:0];
                CFG_LAST_START: r_last_start <= i_cfg_data[EXT_W-1:0];
                CFG_LAST_END:   r_last_end   <= i_cfg_data[EXT_W-1:0];
                CFG_LAST_STEP:  r_last_step  <= i_cfg_data[EXT_W-1:0];
                CFG_OUT_ELEMS:  r_out_elems  <= i_cfg_data[EXT_W-1:0];
                CFG_ELEM_BYTES: r_elem_bytes <= i_cfg_data[EB_W-1:0];
                CFG_FIRST_ROW:  r_first_row  <= i_cfg_data[ROW_W-1:0];
                CFG_ROW_COUNT:  r_row_count  <= i_cfg_data[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    // requests to the walker
    always_comb begin
        w_req         = '0;
        w_req.item    = i_in_item;
        w_req.load    = w_accept && (i_in_item.command == CMD_LOAD);
        w_req.restart = w_accept && (i_in_item.command == CMD_RESTART);
        w_req.start   = w_accept && (i_in_item.command == CMD_STEP) && !w_done;
    end

    nssag_walk u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_req.start ? ST_WALK : ST_RESP;
                end
            end
            ST_WALK: begin
                if (w_rsp.done) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // row counters and walk flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_logical_row   <= '0;
            r_rows_done     <= '0;
            r_start_found   <= 1'b0;
            r_walk_finished <= 1'b0;
            r_emit          <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_emit <= w_req.start && w_emit_now;
            end
            if (w_req.restart) begin
                r_logical_row   <= '0;
                r_rows_done     <= '0;
                r_start_found   <= 1'b0;
                r_walk_finished <= 1'b0;
            end else if (w_req.start) begin
                r_logical_row <= r_logical_row + ROW_W'(1);
                if (w_emit_now) begin
                    r_start_found <= 1'b1;
                    r_rows_done   <= r_rows_done + ROW_W'(1);
                end
            end
            if (r_state == ST_WALK && w_rsp.done && w_rsp.finished) begin
                r_walk_finished <= 1'b1;
            end
        end
    end

    // row length and compaction flag from the innermost dimension
    assign w_bytes     = r_last_size * r_elem_bytes;
    assign w_bytes_sat = (w_bytes > (EXT_W+EB_W)'(ROW_BYTES_MAX)) ? ROW_BYTES_MAX
                                                                 : w_bytes[BYTES_W-1:0];
    assign w_compact   = (r_last_start != '0) || (r_last_step != EXT_W'(1)) ||
                         (r_last_end != r_last_size);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_RESP && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RESP && w_out_free) begin
            r_out.row_emitted      <= r_emit;
            r_out.page_index       <= r_emit ? w_rsp.page : '0;
            r_out.row_bytes        <= w_bytes_sat;
            r_out.needs_compaction <= w_compact;
            r_out.done_res         <= w_done;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ----- rtl/core/nssag_walk.sv -----
// outer dimension tables and the shared multiplier walk for page index and carry
`timescale 1ns / 1ps

module nssag_walk (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  nssag_pkg::t_walk_req i_req,
    output nssag_pkg::t_walk_rsp o_rsp
);
    import nssag_pkg::*;

    logic [EXT_W-1:0] r_size  [OUTER_DIMS];
    logic [EXT_W-1:0] r_start [OUTER_DIMS];
    logic [EXT_W-1:0] r_end   [OUTER_DIMS];
    logic [EXT_W-1:0] r_step  [OUTER_DIMS];
    logic [EXT_W-1:0] r_coord [OUTER_DIMS];

    logic              r_busy;
    logic [DIM_W-1:0]  r_dim;
    logic              r_phase;
    logic              r_carry;
    logic [PAGE_W-1:0] r_idx;
    logic [PAGE_W-1:0] r_mult;
    logic              r_done;
    logic              r_finished;

    logic [EXT_W-1:0]         w_coord;
    logic [EXT_W-1:0]         w_size;
    logic [EXT_W-1:0]         w_opb;
    logic [PAGE_W+EXT_W-1:0]  w_prod;
    logic [EXT_W:0]           w_next;
    logic                     w_fits;
    logic                     w_load_ok;

    // selected dimension and the shared multiplier
    assign w_coord = r_coord[r_dim];
    assign w_size  = r_size[r_dim];
    assign w_opb   = r_phase ? w_size : w_coord;
    assign w_prod  = r_mult * w_opb;

    // coordinate advance without wrap
    assign w_next  = {1'b0, w_coord} + {1'b0, r_step[r_dim]};
    assign w_fits  = w_next < {1'b0, r_end[r_dim]};

    assign w_load_ok = {{(32-IDX_W){1'b0}}, i_req.item.dim_index} < 32'(OUTER_DIMS);

    // dimension tables and coordinates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < OUTER_DIMS; d++) begin
                r_size[d]  <= '0;
                r_start[d] <= '0;
                r_end[d]   <= '0;
                r_step[d]  <= EXT_W'(1);
                r_coord[d] <= '0;
            end
        end else if (i_req.load && w_load_ok) begin
            r_size[i_req.item.dim_index[DIM_W-1:0]]  <= i_req.item.dim_size;
            r_start[i_req.item.dim_index[DIM_W-1:0]] <= i_req.item.dim_start;
            r_end[i_req.item.dim_index[DIM_W-1:0]]   <= i_req.item.dim_end;
            r_step[i_req.item.dim_index[DIM_W-1:0]]  <= i_req.item.dim_step;
        end else if (i_req.restart) begin
            for (int d = 0; d < OUTER_DIMS; d++) begin
                r_coord[d] <= r_start[d];
            end
        end else if (r_busy && r_phase && r_carry) begin
            r_coord[r_dim] <= w_fits ? w_next[EXT_W-1:0] : r_start[r_dim];
        end
    end

    // sequencer: an accumulate phase and a size phase per dimension, innermost outer dimension first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_done     <= 1'b0;
            r_finished <= 1'b0;
            r_dim      <= '0;
            r_phase    <= 1'b0;
            r_carry    <= 1'b0;
            r_idx      <= '0;
            r_mult     <= '0;
        end else begin
            r_done <= !i_req.start && r_busy && r_phase && (r_dim == '0);
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_dim   <= DIM_W'(OUTER_DIMS - 1);
                r_phase <= 1'b0;
                r_carry <= 1'b1;
                r_idx   <= '0;
                r_mult  <= PAGE_W'(1);
            end else if (r_busy) begin
                if (!r_phase) begin
                    // accumulate coordinate times inner size product
                    r_idx   <= r_idx + w_prod[PAGE_W-1:0];
                    r_phase <= 1'b1;
                end else begin
                    // grow the size product and ripple the carry
                    r_mult  <= w_prod[PAGE_W-1:0];
                    r_phase <= 1'b0;
                    if (r_carry && w_fits) begin
                        r_carry <= 1'b0;
                    end
                    if (r_dim == '0) begin
                        r_busy     <= 1'b0;
                        r_finished <= r_carry && !w_fits;
                    end else begin
                        r_dim <= r_dim - DIM_W'(1);
                    end
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.finished = r_finished;
    assign o_rsp.page     = r_idx;

endmodule
